FILE: sv/jhe_pkg.sv
// Shared types, codes and helper functions for the JPEG Huffman symbol encoder.
// No dependencies; jhe_front, jhe_emit and the top level refer to it by scoped names.
package jhe_pkg;

  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int ENTRY_W = CODE_W + LEN_W;

  localparam int BLOCK_COEFFS = 64;
  localparam logic [5:0] LAST_POS = 6'(BLOCK_COEFFS - 1);
  localparam logic [5:0] RUN_MAX  = 6'd63;
  localparam logic [7:0] ZRL_SYM  = 8'hF0;
  localparam logic [4:0] LEN_MAX  = 5'd16;
  localparam logic [4:0] CAT_WIDE = 5'd16;

  // request codes
  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_COEF     = 2'd1;
  localparam logic [1:0] REQ_LOSSLESS = 2'd2;
  localparam logic [1:0] REQ_CLEAR    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_COMP = 2'd1;
  localparam logic [1:0] ST_NO_DC    = 2'd2;
  localparam logic [1:0] ST_NO_AC    = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [5:0]        position;
    logic signed [15:0] sample_value;
    logic [1:0]        component_id;
    logic [1:0]        dc_select;
    logic [1:0]        ac_select;
    logic              load_class;
    logic [1:0]        load_slot;
    logic [7:0]        load_symbol;
    logic [15:0]       load_code;
    logic [4:0]        load_length;
  } in_item_t;

  typedef struct packed {
    logic [15:0] huff_code;
    logic [4:0]  huff_length;
    logic [15:0] extra_bits;
    logic [4:0]  extra_length;
    logic        last_of_run;
    logic [1:0]  status;
  } out_item_t;

  // request handed from the lookup stage to the emit stage
  typedef struct packed {
    logic        valid;
    logic        err;
    logic [1:0]  status;
    logic [1:0]  zrl;
    logic        sym;
    logic [15:0] extra;
    logic [4:0]  elen;
  } look_t;

  // bit length of a magnitude
  function automatic logic [4:0] size_cat(input logic [16:0] mag);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 17; i++) begin
      if (mag[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [15:0] low_mask16(input logic [4:0] n);
    logic [16:0] m;
    m = (17'd1 << n) - 17'd1;
    return m[15:0];
  endfunction

  // value, or value-1 when negative, cut to elen bits
  function automatic logic [15:0] mag_bits(input logic signed [16:0] val,
                                           input logic [4:0] elen);
    logic [16:0] t;
    t = val[16] ? 17'(val - 17'sd1) : 17'(val);
    return t[15:0] & low_mask16(elen);
  endfunction

endpackage

FILE: sv/jhe_ram.sv
// Generic RAM: one write port, two registered read ports, read-first.
// No dependencies.
module jhe_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: sv/jhe_front.sv
// Accept stage and table lookup stage: predictor, run and table state, table
// writes, and the address calculation for the code table. Uses jhe_pkg.
module jhe_front #(
  parameter int TABLE_SLOTS = 4,
  parameter int MAX_COMPONENTS = 4,
  localparam int NT = 2 * TABLE_SLOTS,
  localparam int TW = $clog2(NT),
  localparam int AW = TW + 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  jhe_pkg::in_item_t    in_item,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_wdata,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [jhe_pkg::ENTRY_W-1:0] wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr_main,
  output logic [AW-1:0]        rd_addr_zrl,
  output jhe_pkg::look_t       look,
  input  logic                 look_take
);

  function automatic logic [2:0] tbl_num(input logic cls, input logic [1:0] slot);
    return (cls ? 3'(TABLE_SLOTS) : 3'd0) + {1'b0, slot};
  endfunction

  function automatic logic slot_ok(input logic [1:0] slot);
    return {1'b0, slot} < 3'(TABLE_SLOTS);
  endfunction

  // architectural state
  logic [2:0]         num_comp_r, num_comp_nxt;
  logic [NT-1:0]      loaded_r, loaded_nxt;
  logic signed [15:0] pred_r [MAX_COMPONENTS];
  logic signed [15:0] pred_nxt [MAX_COMPONENTS];
  logic [5:0]         zero_run_r, zero_run_nxt;
  logic               skip_r, skip_nxt;
  logic [1:0]         block_ac_r, block_ac_nxt;

  // lookup stage
  logic               a_valid_r, a_valid_nxt;
  logic               a_err_r, a_err_nxt;
  logic [1:0]         a_status_r, a_status_nxt;
  logic [TW-1:0]      a_tbl_r, a_tbl_nxt;
  logic signed [16:0] a_val_r, a_val_nxt;
  logic [3:0]         a_run_r, a_run_nxt;
  logic               a_ac_r, a_ac_nxt;
  logic               a_ll_r, a_ll_nxt;
  logic [1:0]         a_zrl_r, a_zrl_nxt;
  logic               a_load;

  logic               acc;
  logic [TW-1:0]      dc_tbl, ac_sel_tbl, blk_tbl, ld_tbl;
  logic               dc_use, ac_use, comp_bad;
  logic signed [15:0] pred_sel;
  logic signed [16:0] v_ext, diff;
  logic [5:0]         run_inc;
  logic [4:0]         len_sat;

  assign in_ready = !a_valid_r || look_take;
  assign acc      = in_valid && in_ready;

  assign dc_tbl     = TW'(tbl_num(1'b0, in_item.dc_select));
  assign ac_sel_tbl = TW'(tbl_num(1'b1, in_item.ac_select));
  assign blk_tbl    = TW'(tbl_num(1'b1, block_ac_r));
  assign ld_tbl     = TW'(tbl_num(in_item.load_class, in_item.load_slot));

  assign dc_use   = slot_ok(in_item.dc_select) && loaded_r[dc_tbl];
  assign ac_use   = slot_ok(in_item.ac_select) && loaded_r[ac_sel_tbl];
  assign comp_bad = ({1'b0, in_item.component_id} >= num_comp_r) ||
                    ({1'b0, in_item.component_id} >= 3'(MAX_COMPONENTS));

  always_comb begin
    pred_sel = '0;
    for (int i = 0; i < MAX_COMPONENTS; i++) begin
      if (in_item.component_id == 2'(i)) pred_sel = pred_r[i];
    end
  end

  assign v_ext   = {in_item.sample_value[15], in_item.sample_value};
  assign diff    = v_ext - {pred_sel[15], pred_sel};
  assign run_inc = (zero_run_r < jhe_pkg::RUN_MAX) ? zero_run_r + 6'd1 : zero_run_r;
  assign len_sat = (in_item.load_length > jhe_pkg::LEN_MAX) ? jhe_pkg::LEN_MAX
                                                          : in_item.load_length;

  // table writes land at the accept edge; a lookup ahead in the pipe reads
  // at the same edge and gets the old entry (read-first), later ones the new
  assign wr_en   = acc && (in_item.req_type == jhe_pkg::REQ_LOAD) &&
                   slot_ok(in_item.load_slot);
  assign wr_addr = {ld_tbl, in_item.load_symbol};
  assign wr_data = {len_sat, in_item.load_code & jhe_pkg::low_mask16(len_sat)};

  always_comb begin
    num_comp_nxt = cfg_we ? cfg_wdata : num_comp_r;
    loaded_nxt   = loaded_r;
    pred_nxt     = pred_r;
    zero_run_nxt = zero_run_r;
    skip_nxt     = skip_r;
    block_ac_nxt = block_ac_r;
    a_load       = 1'b0;
    a_err_nxt    = 1'b0;
    a_status_nxt = jhe_pkg::ST_OK;
    a_tbl_nxt    = dc_tbl;
    a_val_nxt    = v_ext;
    a_run_nxt    = '0;
    a_ac_nxt     = 1'b0;
    a_ll_nxt     = 1'b0;
    a_zrl_nxt    = '0;
    if (acc) begin
      unique case (in_item.req_type)
        jhe_pkg::REQ_LOAD: begin
          if (slot_ok(in_item.load_slot)) loaded_nxt[ld_tbl] = 1'b1;
        end
        jhe_pkg::REQ_CLEAR: begin
          for (int i = 0; i < MAX_COMPONENTS; i++) pred_nxt[i] = '0;
        end
        jhe_pkg::REQ_LOSSLESS: begin
          a_load = 1'b1;
          if (!dc_use) begin
            a_err_nxt    = 1'b1;
            a_status_nxt = jhe_pkg::ST_NO_DC;
          end else begin
            a_ll_nxt = 1'b1;
          end
        end
        jhe_pkg::REQ_COEF: begin
          if (in_item.position == '0) begin
            zero_run_nxt = '0;
            a_load       = 1'b1;
            priority if (comp_bad) begin
              skip_nxt     = 1'b1;
              a_err_nxt    = 1'b1;
              a_status_nxt = jhe_pkg::ST_BAD_COMP;
            end else if (!dc_use) begin
              skip_nxt     = 1'b1;
              a_err_nxt    = 1'b1;
              a_status_nxt = jhe_pkg::ST_NO_DC;
            end else if (!ac_use) begin
              skip_nxt     = 1'b1;
              a_err_nxt    = 1'b1;
              a_status_nxt = jhe_pkg::ST_NO_AC;
            end else begin
              skip_nxt     = 1'b0;
              block_ac_nxt = in_item.ac_select;
              a_val_nxt    = diff;
              for (int i = 0; i < MAX_COMPONENTS; i++) begin
                if (in_item.component_id == 2'(i)) pred_nxt[i] = in_item.sample_value;
              end
            end
          end else if (!skip_r) begin
            a_tbl_nxt = blk_tbl;
            a_ac_nxt  = 1'b1;
            if (in_item.sample_value == '0) begin
              if (in_item.position == jhe_pkg::LAST_POS) begin
                // end of block with zeros pending: EOB is run 0, size 0
                a_load       = 1'b1;
                zero_run_nxt = '0;
              end else begin
                zero_run_nxt = run_inc;
              end
            end else begin
              a_load       = 1'b1;
              a_zrl_nxt    = zero_run_r[5:4];
              a_run_nxt    = zero_run_r[3:0];
              zero_run_nxt = '0;
            end
          end
        end
        default: ;
      endcase
    end
    a_valid_nxt = (a_valid_r && !look_take) || a_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_comp_r <= 3'd1;
      loaded_r   <= '0;
      zero_run_r <= '0;
      skip_r     <= 1'b0;
      block_ac_r <= '0;
      a_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_COMPONENTS; i++) pred_r[i] <= '0;
    end else begin
      num_comp_r <= num_comp_nxt;
      loaded_r   <= loaded_nxt;
      zero_run_r <= zero_run_nxt;
      skip_r     <= skip_nxt;
      block_ac_r <= block_ac_nxt;
      a_valid_r  <= a_valid_nxt;
      for (int i = 0; i < MAX_COMPONENTS; i++) pred_r[i] <= pred_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_err_r    <= a_err_nxt;
      a_status_r <= a_status_nxt;
      a_tbl_r    <= a_tbl_nxt;
      a_val_r    <= a_val_nxt;
      a_run_r    <= a_run_nxt;
      a_ac_r     <= a_ac_nxt;
      a_ll_r     <= a_ll_nxt;
      a_zrl_r    <= a_zrl_nxt;
    end
  end

  // size category and symbol index of the held item
  logic [16:0] a_mag;
  logic [4:0]  a_cat, a_elen;
  logic [7:0]  a_sym;

  assign a_mag  = a_val_r[16] ? 17'(-a_val_r) : 17'(a_val_r);
  assign a_cat  = jhe_pkg::size_cat(a_mag);
  assign a_sym  = a_ac_r ? ({a_run_r, 4'h0} + {3'b000, a_cat}) : {3'b000, a_cat};
  assign a_elen = (a_ll_r && a_cat == jhe_pkg::CAT_WIDE) ? 5'd0 : a_cat;

  assign rd_en        = a_valid_r && look_take;
  assign rd_addr_main = {a_tbl_r, a_sym};
  assign rd_addr_zrl  = {a_tbl_r, jhe_pkg::ZRL_SYM};

  assign look.valid  = a_valid_r;
  assign look.err    = a_err_r;
  assign look.status = a_status_r;
  assign look.zrl    = a_zrl_r;
  assign look.sym    = !a_err_r;
  assign look.extra  = jhe_pkg::mag_bits(a_val_r, a_elen);
  assign look.elen   = a_elen;

endmodule

FILE: sv/jhe_emit.sv
// Emit stage: turns one looked-up item into its ZRL, symbol or status results
// and drives the output register. Uses jhe_pkg.
module jhe_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  jhe_pkg::look_t              look,
  output logic                        look_take,
  input  logic [jhe_pkg::ENTRY_W-1:0] rd_main,
  input  logic [jhe_pkg::ENTRY_W-1:0] rd_zrl,
  output logic                        out_valid,
  input  logic                        out_ready,
  output jhe_pkg::out_item_t          out_item
);

  logic               b_valid_r, b_valid_nxt;
  logic               b_err_r;
  logic [1:0]         b_status_r;
  logic [1:0]         b_zrl_r, b_zrl_nxt;
  logic               b_sym_r;
  logic [15:0]        b_extra_r;
  logic [4:0]         b_elen_r;
  logic               out_valid_r, out_valid_nxt;
  jhe_pkg::out_item_t out_item_r, out_item_nxt;

  logic [4:0] mlen, zlen;
  logic       has_zrl, has_main, emit, last, out_free, fire, b_done;

  assign mlen     = rd_main[jhe_pkg::ENTRY_W-1:jhe_pkg::CODE_W];
  assign zlen     = rd_zrl[jhe_pkg::ENTRY_W-1:jhe_pkg::CODE_W];
  assign has_zrl  = (b_zrl_r != '0) && (zlen != '0);
  assign has_main = b_err_r || (b_sym_r && mlen != '0);
  assign emit     = b_valid_r && (has_zrl || has_main);
  assign last     = has_zrl ? (b_zrl_r == 2'd1 && !has_main) : 1'b1;
  assign out_free = !out_valid_r || out_ready;
  assign fire     = emit && out_free;
  assign b_done   = b_valid_r && (!emit || (out_free && last));
  assign look_take = !b_valid_r || b_done;

  always_comb begin
    out_item_nxt.last_of_run = last;
    out_item_nxt.status      = jhe_pkg::ST_OK;
    if (has_zrl) begin
      out_item_nxt.huff_code    = rd_zrl[jhe_pkg::CODE_W-1:0];
      out_item_nxt.huff_length  = zlen;
      out_item_nxt.extra_bits   = '0;
      out_item_nxt.extra_length = '0;
    end else if (b_err_r) begin
      out_item_nxt.huff_code    = '0;
      out_item_nxt.huff_length  = '0;
      out_item_nxt.extra_bits   = '0;
      out_item_nxt.extra_length = '0;
      out_item_nxt.status       = b_status_r;
    end else begin
      out_item_nxt.huff_code    = rd_main[jhe_pkg::CODE_W-1:0];
      out_item_nxt.huff_length  = mlen;
      out_item_nxt.extra_bits   = b_extra_r;
      out_item_nxt.extra_length = b_elen_r;
    end
  end

  always_comb begin
    b_valid_nxt = look_take ? look.valid : b_valid_r;
    b_zrl_nxt   = b_zrl_r;
    if (look_take) begin
      b_zrl_nxt = look.zrl;
    end else if (fire && has_zrl) begin
      b_zrl_nxt = b_zrl_r - 2'd1;
    end
    out_valid_nxt = fire || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_zrl_r <= b_zrl_nxt;
    if (look_take) begin
      b_err_r    <= look.err;
      b_status_r <= look.status;
      b_sym_r    <= look.sym;
      b_extra_r  <= look.extra;
      b_elen_r   <= look.elen;
    end
    if (fire) out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: sv/jpeg_huffman_symbol_encoder_core.sv
// Top level of the JPEG Huffman symbol encoder: code table RAM, accept and
// lookup stage, emit stage. Uses jhe_pkg, jhe_ram, jhe_front and jhe_emit.
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid / in_ready  jhe_pkg::in_item_t
//   out_*        output     out_valid/out_ready  jhe_pkg::out_item_t
//   cfg_*        input      cfg_we (no wait)     num_components, 3 bits
//
// One item is accepted per cycle while in_ready is high. A coefficient that
// flushes pending zeros emits up to three ZRL symbols ahead of its own; the
// emit stage drains one symbol per cycle into the output register while the
// output is not stalled, so such an item holds the input back until its
// ZRLs are out. The path to the first result runs through the lookup
// register at acceptance, the table read, then the output register.
// Reset clears predictors, zero run, table-in-use bits and all valid flags
// at once; the code table itself needs no clearing pass and is undefined
// until loaded. Output stalls back up through the two stages to in_ready.
module jpeg_huffman_symbol_encoder_core #(
  parameter int TABLE_SLOTS = 4,
  parameter int MAX_COMPONENTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jhe_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output jhe_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata
);

  // one table of 256 symbols per class and slot, DC tables first
  localparam int DEPTH = 2 * TABLE_SLOTS * 256;
  localparam int AW    = $clog2(DEPTH);

  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr_main, rd_addr_zrl;
  logic [jhe_pkg::ENTRY_W-1:0] wr_data, rd_main, rd_zrl;
  jhe_pkg::look_t              look;
  logic                        look_take;

  // table entries: length in the top bits, code right aligned below
  jhe_ram #(
    .WIDTH (jhe_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (rd_en),
    .raddr_a (rd_addr_main),
    .raddr_b (rd_addr_zrl),
    .rdata_a (rd_main),
    .rdata_b (rd_zrl)
  );

  // accept stage updates all block state at the handshake; lookup stage
  // computes the symbol index and fires both table reads as it advances
  jhe_front #(
    .TABLE_SLOTS    (TABLE_SLOTS),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr_main (rd_addr_main),
    .rd_addr_zrl  (rd_addr_zrl),
    .look         (look),
    .look_take    (look_take)
  );

  // emit stage holds the read data until every symbol of the item is out;
  // absent symbols drop, and the last one carries last_of_run
  jhe_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .look      (look),
    .look_take (look_take),
    .rd_main   (rd_main),
    .rd_zrl    (rd_zrl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for jpeg_huffman_symbol_encoder_core: a random driver, a ready
// generator, a monitor and a symbol predictor, all in this one module.
// Depends on jhe_pkg for the item types and the request and status codes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 4;    // Huffman table slots per class
  localparam int COMP_MAX    = 4;    // components the block can track
  localparam int RUN_STEP    = 16;   // zeros covered by one ZRL
  localparam int EOB_SYM     = 0;    // end-of-block symbol index
  localparam int DC_CLASS    = 0;
  localparam int AC_CLASS    = 1;
  localparam int DC_SYMS     = 17;   // DC categories 0..16
  localparam int AC_FILLED   = 2;    // AC slots that get entries
  localparam int AC_SIZE_MAX = 2;    // largest size of random AC values

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  jhe_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  jhe_pkg::out_item_t out_item;
  logic               cfg_we    = 1'b0;
  logic [2:0]         cfg_wdata = 3'd1;

  jpeg_huffman_symbol_encoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bench bookkeeping
  // ---------------------------------------------------------------------------
  jhe_pkg::in_item_t  coef_stream [$];   // items waiting for the driver
  jhe_pkg::out_item_t symbols_due [$];   // predicted symbols, oldest first
  jhe_pkg::out_item_t sym_burst [$];     // symbols of the item being predicted

  int n_queued     = 0;
  int n_sent       = 0;
  int n_accepted   = 0;
  int n_results    = 0;
  int n_errors     = 0;
  int n_cfg_writes = 0;

  bit quiet         = 1'b0;   // no idling on either side
  bit drain_request = 1'b0;   // ask the driver to pause once for a full drain
  bit drain_hold    = 1'b0;
  int in_gap        = 0;
  int stall_left    = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the tables, predictors and run counter
  // ---------------------------------------------------------------------------
  logic [15:0] code_bits [0:2*SLOTS*256-1];
  logic [4:0]  code_len  [0:2*SLOTS*256-1];
  logic [7:0]  tab_used  = '0;       // bit class*SLOTS + slot
  int          dc_hist [COMP_MAX];   // last DC value per component
  int          zrun    = 0;
  bit          skip    = 1'b0;       // block rejected at its DC item
  int          blk_ac  = 0;          // AC slot latched at the block's DC item
  int          ncomp   = 1;          // copy of num_components

  function automatic int unsigned ones(input int unsigned n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  // number of significant bits of a magnitude
  function automatic int unsigned bit_size(input int unsigned m);
    int unsigned n;
    n = 0;
    while (m != 0) begin
      n++;
      m = m >> 1;
    end
    return n;
  endfunction

  function automatic int unsigned abs_val(input int v);
    return (v < 0) ? int'(-v) : v;
  endfunction

  // Look up one symbol; drop it when the stored length marks it absent or the burst is full.
  task automatic add_symbol(input int cls, input int slot, input int sym,
                            input int value, input int unsigned elen);
    int                 idx;
    int unsigned        len;
    jhe_pkg::out_item_t r;
    idx = (cls * SLOTS + slot) * 256 + (sym & 255);
    len = code_len[idx];
    if (len == 0 || sym_burst.size() >= 4) return;
    r.huff_code    = 16'(code_bits[idx] & ones(len));
    r.huff_length  = 5'(len);
    r.extra_bits   = 16'((value < 0 ? value - 1 : value) & ones(elen));
    r.extra_length = 5'(elen);
    r.last_of_run  = 1'b0;
    r.status       = jhe_pkg::ST_OK;
    sym_burst.push_back(r);
  endtask

  task automatic add_status(input logic [1:0] st);
    jhe_pkg::out_item_t r;
    r        = '0;
    r.status = st;
    if (sym_burst.size() < 4) sym_burst.push_back(r);
  endtask

  // Work out the symbols one accepted item causes and append them to symbols_due.
  task automatic encode_item(input jhe_pkg::in_item_t it);
    int          v;
    int          diff;
    int unsigned cat;
    int unsigned len;
    int          idx;
    sym_burst.delete();
    v = $signed(it.sample_value);
    case (it.req_type)
      jhe_pkg::REQ_LOAD: begin
        // saturate the length, mask the code to it, mark the table in use
        len = (it.load_length > jhe_pkg::LEN_MAX) ? jhe_pkg::LEN_MAX : it.load_length;
        idx = (it.load_class * SLOTS + it.load_slot) * 256 + it.load_symbol;
        code_bits[idx] = 16'(it.load_code & ones(len));
        code_len[idx]  = 5'(len);
        tab_used[it.load_class * SLOTS + it.load_slot] = 1'b1;
      end
      jhe_pkg::REQ_CLEAR: begin
        foreach (dc_hist[i]) dc_hist[i] = 0;
      end
      jhe_pkg::REQ_LOSSLESS: begin
        if (!tab_used[DC_CLASS * SLOTS + it.dc_select]) begin
          add_status(jhe_pkg::ST_NO_DC);
        end else begin
          cat = bit_size(abs_val(v));
          add_symbol(DC_CLASS, it.dc_select, cat, v, (cat == jhe_pkg::CAT_WIDE) ? 0 : cat);
        end
      end
      default: begin
        if (it.position == 0) begin
          // block start: component, then DC table, then AC table
          zrun = 0;
          if (it.component_id >= ncomp || it.component_id >= COMP_MAX) begin
            skip = 1'b1;
            add_status(jhe_pkg::ST_BAD_COMP);
          end else if (!tab_used[DC_CLASS * SLOTS + it.dc_select]) begin
            skip = 1'b1;
            add_status(jhe_pkg::ST_NO_DC);
          end else if (!tab_used[AC_CLASS * SLOTS + it.ac_select]) begin
            skip = 1'b1;
            add_status(jhe_pkg::ST_NO_AC);
          end else begin
            diff = v - dc_hist[it.component_id];
            cat  = bit_size(abs_val(diff));
            skip = 1'b0;
            blk_ac = it.ac_select;
            dc_hist[it.component_id] = v;
            add_symbol(DC_CLASS, it.dc_select, cat, diff, cat);
          end
        end else if (!skip) begin
          if (v == 0) begin
            if (zrun < jhe_pkg::RUN_MAX) zrun++;
          end else begin
            cat = bit_size(abs_val(v));
            // flush pending zeros as ZRLs, then run/size (wraps at size 16)
            while (zrun > RUN_STEP - 1) begin
              add_symbol(AC_CLASS, blk_ac, jhe_pkg::ZRL_SYM, 0, 0);
              zrun -= RUN_STEP;
            end
            add_symbol(AC_CLASS, blk_ac, ((zrun << 4) + cat) & 255, v, cat);
            zrun = 0;
          end
          if (it.position == jhe_pkg::LAST_POS && zrun > 0) begin
            add_symbol(AC_CLASS, blk_ac, EOB_SYM, 0, 0);
            zrun = 0;
          end
        end
      end
    endcase
    if (sym_burst.size() > 0) sym_burst[sym_burst.size() - 1].last_of_run = 1'b1;
    foreach (sym_burst[i]) symbols_due.push_back(sym_burst[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge, hold an item until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (n_sent != n_accepted) begin
      // hold valid and payload until the handshake
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (drain_hold) begin
      // pause until every predicted symbol has come out
      in_valid <= 1'b0;
      if (symbols_due.size() == 0) drain_hold = 1'b0;
    end else if (coef_stream.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      // open an idle burst that starts with this cycle
      in_valid <= 1'b0;
      in_gap = $urandom_range(1, 8) - 1;
    end else if (drain_request || (!quiet && $urandom_range(0, 59) == 0)) begin
      in_valid <= 1'b0;
      drain_request = 1'b0;
      drain_hold    = 1'b1;
    end else begin
      in_item  <= coef_stream.pop_front();
      in_valid <= 1'b1;
      n_sent++;
    end
  end

  // Receiver side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check symbols against the oldest prediction, then predict the
  // item accepted at this edge
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    jhe_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (symbols_due.size() == 0) begin
          $error("symbol with nothing predicted: code 0x%0h length %0d status %0d",
                 out_item.huff_code, out_item.huff_length, out_item.status);
          n_errors++;
        end else begin
          want = symbols_due.pop_front();
          check_field("huff_code", want.huff_code, out_item.huff_code);
          check_field("huff_length", want.huff_length, out_item.huff_length);
          check_field("extra_bits", want.extra_bits, out_item.extra_bits);
          check_field("extra_length", want.extra_length, out_item.extra_length);
          check_field("last_of_run", want.last_of_run, out_item.last_of_run);
          check_field("status", want.status, out_item.status);
        end
      end
      if (in_valid && in_ready) begin
        encode_item(in_item);
        n_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item builders; every field not set on purpose stays random
  // ---------------------------------------------------------------------------
  function automatic jhe_pkg::in_item_t rand_item();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(jhe_pkg::in_item_t)-1:0];
  endfunction

  // small nonzero AC value, size 1 to AC_SIZE_MAX
  function automatic int rand_ac_sample();
    int m;
    m = $urandom_range(1, 3);
    return ($urandom_range(0, 1) == 0) ? m : -m;
  endfunction

  // random item that stays on table entries that were loaded
  function automatic jhe_pkg::in_item_t wild_item();
    jhe_pkg::in_item_t r;
    r = rand_item();
    if (r.req_type == jhe_pkg::REQ_COEF && r.position != '0)
      r.sample_value = 16'(rand_ac_sample());
    if (r.req_type == jhe_pkg::REQ_LOAD && r.load_class == 1'(AC_CLASS))
      r.load_slot[1] = 1'b0;
    return r;
  endfunction

  function automatic jhe_pkg::in_item_t load_item(input int cls, input int slot,
                                                  input int sym, input int code,
                                                  input int len);
    jhe_pkg::in_item_t r;
    r = rand_item();
    r.req_type    = jhe_pkg::REQ_LOAD;
    r.load_class  = 1'(cls);
    r.load_slot   = 2'(slot);
    r.load_symbol = 8'(sym);
    r.load_code   = 16'(code);
    r.load_length = 5'(len);
    return r;
  endfunction

  function automatic jhe_pkg::in_item_t coef_item(input int pos, input int val,
                                                  input int comp, input int dsel,
                                                  input int asel);
    jhe_pkg::in_item_t r;
    r = rand_item();
    r.req_type     = jhe_pkg::REQ_COEF;
    r.position     = 6'(pos);
    r.sample_value = 16'(val);
    r.component_id = 2'(comp);
    r.dc_select    = 2'(dsel);
    r.ac_select    = 2'(asel);
    return r;
  endfunction

  function automatic jhe_pkg::in_item_t lossless_item(input int val, input int dsel);
    jhe_pkg::in_item_t r;
    r = rand_item();
    r.req_type     = jhe_pkg::REQ_LOSSLESS;
    r.sample_value = 16'(val);
    r.dc_select    = 2'(dsel);
    return r;
  endfunction

  function automatic jhe_pkg::in_item_t clear_item();
    jhe_pkg::in_item_t r;
    r = rand_item();
    r.req_type = jhe_pkg::REQ_CLEAR;
    return r;
  endfunction

  // mostly real code lengths, some absent, some above 16 to saturate
  function automatic int rand_len();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(17, 31);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 6)) - 3;
      1: return int'($urandom_range(0, 510)) - 255;
      2: return $signed(16'($urandom()));
      default: begin
        case ($urandom_range(0, 3))
          0:       return -32768;
          1:       return 32767;
          2:       return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  task automatic queue_item(input jhe_pkg::in_item_t it);
    coef_stream.push_back(it);
    n_queued++;
  endtask

  // One block: a DC item, AC items, sometimes closed at the last position.
  // A long block piles up zeros to force ZRLs.
  task automatic push_block(input int ncomp_now);
    int comp;
    int asel;
    int n_ac;
    int zero_pct;
    comp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                       : $urandom_range(0, ncomp_now - 1);
    // mostly a filled AC slot, now and then an unused one
    asel = ($urandom_range(0, 7) == 0) ? $urandom_range(AC_FILLED, SLOTS - 1)
                                       : $urandom_range(0, AC_FILLED - 1);
    queue_item(coef_item(0, rand_sample(), comp, $urandom_range(0, 3), asel));
    if ($urandom_range(0, 5) == 0) begin
      n_ac     = $urandom_range(16, 40);
      zero_pct = 90;
    end else begin
      n_ac     = $urandom_range(1, 10);
      zero_pct = 50;
    end
    repeat (n_ac) begin
      queue_item(coef_item($urandom_range(1, jhe_pkg::LAST_POS - 1),
                           ($urandom_range(1, 100) <= zero_pct) ? 0 : rand_ac_sample(),
                           $urandom_range(0, 3), $urandom_range(0, 3),
                           $urandom_range(0, 3)));
    end
    if ($urandom_range(0, 1) == 0) begin
      queue_item(coef_item(jhe_pkg::LAST_POS,
                           ($urandom_range(0, 2) != 0) ? 0 : rand_ac_sample(),
                           $urandom_range(0, 3), $urandom_range(0, 3),
                           $urandom_range(0, 3)));
    end
  endtask

  // Wait for the block to go idle, then let the pipeline settle.
  task automatic wait_drained();
    while (coef_stream.size() != 0 || n_sent != n_accepted || symbols_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Write num_components while idle; update the predictor's copy with it.
  task automatic set_components(input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= 3'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    ncomp = value;
    n_cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int settings [5];
    int start;
    int pick;
    foreach (code_len[i]) begin
      code_len[i]  = '0;
      code_bits[i] = '0;
    end
    foreach (dc_hist[i]) dc_hist[i] = 0;

    // hold reset, then release it at a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Error paths while the tables are still empty: no entry is used here.
    queue_item(lossless_item(5, 2));           // lossless with an unused DC table
    queue_item(coef_item(0, 100, 1, 0, 0));    // component above num_components
    queue_item(coef_item(7, -9, 0, 0, 0));     // AC of a rejected block: dropped
    queue_item(coef_item(jhe_pkg::LAST_POS, 0, 0, 0, 0));
    queue_item(clear_item());
    queue_item(coef_item(0, 3, 0, 3, 0));      // unused DC table at block start

    // Fill every DC symbol that a category can address
    for (int s = 0; s < SLOTS; s++)
      for (int k = 0; k < DC_SYMS; k++)
        queue_item(load_item(DC_CLASS, s, k, $urandom(), rand_len()));
    queue_item(coef_item(0, 3, 0, 1, 2));      // DC table ok, AC table unused

    // Fill ZRL, EOB and the run/size symbols that small AC values reach
    for (int s = 0; s < AC_FILLED; s++) begin
      queue_item(load_item(AC_CLASS, s, jhe_pkg::ZRL_SYM, $urandom(), rand_len()));
      queue_item(load_item(AC_CLASS, s, EOB_SYM, $urandom(), rand_len()));
      for (int r = 0; r < RUN_STEP; r++)
        for (int z = 1; z <= AC_SIZE_MAX; z++)
          queue_item(load_item(AC_CLASS, s, r * RUN_STEP + z, $urandom(), rand_len()));
    end

    // Pin the entries the directed items below rely on
    queue_item(load_item(DC_CLASS, 0, 15, 16'hFFFF, 5));    // code masked to length
    queue_item(load_item(DC_CLASS, 0, 16, 16'hFFFF, 31));   // length saturates
    queue_item(load_item(AC_CLASS, 0, jhe_pkg::ZRL_SYM, 16'h07F9, 11));
    queue_item(load_item(AC_CLASS, 0, EOB_SYM, 16'h000A, 4));
    queue_item(load_item(AC_CLASS, 0, 8'h01, 16'h0003, 0)); // absent symbol
    queue_item(load_item(AC_CLASS, 0, 8'h4F, 16'h1234, 16));

    queue_item(coef_item(0, 32767, 0, 0, 0));  // largest positive DC difference
    queue_item(coef_item(1, 1, 0, 0, 0));      // absent symbol: nothing comes out
    // run of 15 zeros, then size 16: symbol index wraps to zero
    repeat (15) queue_item(coef_item(5, 0, 0, 0, 0));
    queue_item(coef_item(20, -32768, 0, 0, 0));
    // 20 zeros then a value: one ZRL ahead of run/size
    repeat (20) queue_item(coef_item(9, 0, 0, 0, 0));
    queue_item(coef_item(30, 32767, 0, 0, 0));
    queue_item(coef_item(31, 0, 0, 0, 0));
    queue_item(coef_item(jhe_pkg::LAST_POS, 0, 0, 0, 0));   // zeros pending: EOB
    queue_item(coef_item(0, -32768, 0, 0, 0));              // DC difference of category 16
    queue_item(coef_item(jhe_pkg::LAST_POS, 3, 0, 0, 0));   // nonzero last: no EOB
    queue_item(lossless_item(-32768, 0));                   // category 16, no extra bits
    queue_item(lossless_item(0, 0));
    queue_item(clear_item());
    queue_item(coef_item(0, -1, 0, 0, 0));

    wait_drained();
    set_components(COMP_MAX);
    queue_item(coef_item(0, 7, 3, 2, 1));          // highest component now valid

    // Random phases, one num_components setting each; the last has no idling
    settings = '{4, 2, 1, 3, 4};
    foreach (settings[p]) begin
      wait_drained();
      set_components(settings[p]);
      quiet = (p == 4);
      if (p == 0) drain_request = 1'b1;
      start = n_queued;
      while (n_queued - start < 20) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          push_block(settings[p]);
        else if (pick < 80)
          queue_item(lossless_item(rand_sample(), $urandom_range(0, 3)));
        else if (pick < 85)
          queue_item(clear_item());
        else if (pick < 92)
          queue_item(load_item($urandom_range(0, 1), $urandom_range(0, 1),
                               $urandom_range(0, 255), $urandom(), rand_len()));
        else
          queue_item(wild_item());   // anything on the loaded entries
      end
    end

    wait_drained();
    $display("Covered %0d input items, %0d symbols, %0d num_components writes; %0d errors",
             n_accepted, n_results, n_cfg_writes, n_errors);
    if (n_errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog, well above the slowest legal run
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/jhe_pkg.sv
sv/jhe_ram.sv
sv/jhe_front.sv
sv/jhe_emit.sv
sv/jpeg_huffman_symbol_encoder_core.sv
tb/sv/tb.sv
